[design/rgb_to_hsl_adjust_defines.svh]
// Assertion macros used by the top-level RTL file.
`ifndef RGB_TO_HSL_ADJUST_DEFINES_SVH
`define RGB_TO_HSL_ADJUST_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define RTHSL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RTHSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/rthsl_pkg.sv]
package rthsl_pkg;

  localparam int HUE_FRAC_BITS = 6;
  localparam int PCT_FRAC_BITS = 8;
  localparam int HUE_MAX       = 360 << HUE_FRAC_BITS;
  localparam int PCT_MAX       = 100 << PCT_FRAC_BITS;
  localparam int PCT_SCALE2    = 2 * PCT_MAX;

  localparam int PIX_W = 64;
  localparam int CH_W  = 16;
  localparam int NUM_W = 32;
  localparam int DEN_W = 18;
  localparam int QUO_W = 16;
  localparam int OUT_W = 15;
  localparam int OFS_W = 16;
  localparam int FMT_W = 3;
  localparam int CFG_ADDR_W = 2;

  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 1;

  typedef enum logic [FMT_W-1:0] {
    FMT_BGRA8  = 3'd0,
    FMT_BGRA16 = 3'd1,
    FMT_ARGB8  = 3'd2,
    FMT_ARGB16 = 3'd3,
    FMT_RGB10  = 3'd4
  } fmt_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FORMAT     = 2'd0,
    CFG_HUE_OFS    = 2'd1,
    CFG_SAT_OFS    = 2'd2,
    CFG_LIGHT_OFS  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    div_req_t hue;
    div_req_t sat;
    div_req_t light;
  } div_bundle_t;

  function automatic logic [CH_W-1:0] sat16(input logic [CH_W-1:0] v);
    logic [CH_W-1:0] lim;
    lim = CH_W'(32768);
    return (v > lim) ? lim : v;
  endfunction

endpackage

[design/rgb_to_hsl_adjust.sv]
// RGB to HSL conversion with signed hue, saturation and lightness offsets.
// Input stream: one 64-bit packed pixel per beat on in_tdata, unpacked by
// the pixel format register (BGRA8, BGRA16, ARGB8, ARGB16, RGB10).
// Output stream: one beat per pixel, out_tdata = {3'b0, lightness,
// saturation, hue}, each 15 bits; hue in 1/64 degree clamped to 0..360,
// saturation and lightness in 1/256 percent clamped to 0..100.
// Configuration: cfg_wr_en with cfg_addr 0 format, 1 hue offset,
// 2 saturation offset, 3 lightness offset; write only while idle.
// A pixel passes four operand stages, sixteen stages of the restoring
// dividers (one quotient bit each) and one offset/clamp register on its way
// to out_tvalid. Throughput is one pixel per clock while not stalled.
// The pipeline advances as a whole; when out_tvalid is high and
// out_tready low, every stage holds and in_tready drops, so no beat
// is lost or repeated. Empty slots do not block intake.
// Synchronous active-low reset clears the valid chain and all registers
// of configuration to zero (BGRA8, no offsets).
module rgb_to_hsl_adjust (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,   // pixel_word[63:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [47:0]                         out_tdata,  // hue[14:0], saturation[29:15],
                                                          // lightness[44:30], zero pad
  input  logic                                cfg_wr_en,
  input  logic [rthsl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [15:0]                         cfg_wdata
);

  `include "rgb_to_hsl_adjust_defines.svh"

  localparam int LAT = rthsl_pkg::FRONT_STAGES + rthsl_pkg::QUO_W + rthsl_pkg::BACK_STAGES;
  localparam int OW  = rthsl_pkg::OUT_W;

  logic [rthsl_pkg::FMT_W-1:0]        fmt_r;
  logic signed [rthsl_pkg::OFS_W-1:0] hue_ofs_r, sat_ofs_r, light_ofs_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= '0;
      hue_ofs_r   <= '0;
      sat_ofs_r   <= '0;
      light_ofs_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rthsl_pkg::CFG_FORMAT:    fmt_r       <= cfg_wdata[rthsl_pkg::FMT_W-1:0];
        rthsl_pkg::CFG_HUE_OFS:   hue_ofs_r   <= cfg_wdata;
        rthsl_pkg::CFG_SAT_OFS:   sat_ofs_r   <= cfg_wdata;
        rthsl_pkg::CFG_LIGHT_OFS: light_ofs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance everything unless the output beat is stuck
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n)  vld_r <= '0;
    else if (en) vld_r <= vld_nxt;
  end

  assign out_tvalid = vld_r[LAT-1];

  rthsl_pkg::div_bundle_t req;
  logic [rthsl_pkg::QUO_W-1:0] hue_q, sat_q, light_q;
  logic [OW-1:0] hue, saturation, lightness;

  rthsl_front u_front (
    .clk (clk),
    .en  (en),
    .fmt (fmt_r),
    .pix (in_tdata),
    .req (req)
  );

  rthsl_div u_div_hue   (.clk(clk), .en(en), .req(req.hue),   .quot(hue_q));
  rthsl_div u_div_sat   (.clk(clk), .en(en), .req(req.sat),   .quot(sat_q));
  rthsl_div u_div_light (.clk(clk), .en(en), .req(req.light), .quot(light_q));

  rthsl_back u_back (
    .clk        (clk),
    .en         (en),
    .hue_raw    (hue_q),
    .sat_raw    (sat_q),
    .light_raw  (light_q),
    .hue_ofs    (hue_ofs_r),
    .sat_ofs    (sat_ofs_r),
    .light_ofs  (light_ofs_r),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  assign out_tdata = {3'b000, lightness, saturation, hue};

  `RTHSL_ASSERT_ALWAYS(a_hue_range, !out_tvalid || (hue <= OW'(rthsl_pkg::HUE_MAX)), "hue out of range")
  `RTHSL_ASSERT_ALWAYS(a_sat_range, !out_tvalid || (saturation <= OW'(rthsl_pkg::PCT_MAX)), "sat out of range")
  `RTHSL_ASSERT_ALWAYS(a_light_range, !out_tvalid || (lightness <= OW'(rthsl_pkg::PCT_MAX)), "light out of range")
  `RTHSL_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0], "accepted beat missing")
  `RTHSL_ASSERT_NEXT(a_hold_chain, !en, $stable(vld_r), "valid chain moved during stall")

endmodule

[design/rthsl_front.sv]
module rthsl_front (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [rthsl_pkg::FMT_W-1:0]             fmt,
  input  logic [rthsl_pkg::PIX_W-1:0]             pix,
  output rthsl_pkg::div_bundle_t                  req
);

  localparam logic [1:0] SEL_R = 2'd0;
  localparam logic [1:0] SEL_G = 2'd1;
  localparam logic [1:0] SEL_B = 2'd2;

  localparam int CW = rthsl_pkg::CH_W;
  localparam int TW = 27;

  // stage 1: unpack
  logic [CW-1:0] r1_r, g1_r, b1_r, fs1_r;
  logic [CW-1:0] r1_nxt, g1_nxt, b1_nxt, fs1_nxt;

  always_comb begin
    case (fmt)
      rthsl_pkg::FMT_BGRA16: begin
        b1_nxt = rthsl_pkg::sat16(pix[15:0]);
        g1_nxt = rthsl_pkg::sat16(pix[31:16]);
        r1_nxt = rthsl_pkg::sat16(pix[47:32]);
        fs1_nxt = CW'(32768);
      end
      rthsl_pkg::FMT_ARGB8: begin
        r1_nxt = CW'(pix[15:8]);
        g1_nxt = CW'(pix[23:16]);
        b1_nxt = CW'(pix[31:24]);
        fs1_nxt = CW'(255);
      end
      rthsl_pkg::FMT_ARGB16: begin
        r1_nxt = rthsl_pkg::sat16(pix[31:16]);
        g1_nxt = rthsl_pkg::sat16(pix[47:32]);
        b1_nxt = rthsl_pkg::sat16(pix[63:48]);
        fs1_nxt = CW'(32768);
      end
      rthsl_pkg::FMT_RGB10: begin
        b1_nxt = CW'(pix[11:2]);
        g1_nxt = CW'(pix[21:12]);
        r1_nxt = CW'(pix[31:22]);
        fs1_nxt = CW'(1024);
      end
      default: begin
        b1_nxt = CW'(pix[7:0]);
        g1_nxt = CW'(pix[15:8]);
        r1_nxt = CW'(pix[23:16]);
        fs1_nxt = CW'(255);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= r1_nxt;
      g1_r  <= g1_nxt;
      b1_r  <= b1_nxt;
      fs1_r <= fs1_nxt;
    end
  end

  // stage 2: max, min, hue difference
  logic [CW:0]   s2_r, s2_nxt;
  logic [CW-1:0] d2_r, d2_nxt, fs2_r;
  logic signed [CW:0] dif2_r, dif2_nxt;
  logic [1:0]    sel2_r, sel2_nxt;
  logic [CW-1:0] mx, mn;

  always_comb begin
    mx = r1_r;
    if (g1_r > mx) mx = g1_r;
    if (b1_r > mx) mx = b1_r;
    mn = r1_r;
    if (g1_r < mn) mn = g1_r;
    if (b1_r < mn) mn = b1_r;
    s2_nxt = {1'b0, mx} + {1'b0, mn};
    d2_nxt = mx - mn;
    if (r1_r == mx) begin
      sel2_nxt = SEL_R;
      dif2_nxt = $signed({1'b0, g1_r}) - $signed({1'b0, b1_r});
    end else if (g1_r == mx) begin
      sel2_nxt = SEL_G;
      dif2_nxt = $signed({1'b0, b1_r}) - $signed({1'b0, r1_r});
    end else begin
      sel2_nxt = SEL_B;
      dif2_nxt = $signed({1'b0, r1_r}) - $signed({1'b0, g1_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s2_nxt;
      d2_r   <= d2_nxt;
      dif2_r <= dif2_nxt;
      sel2_r <= sel2_nxt;
      fs2_r  <= fs1_r;
    end
  end

  // stage 3: hue numerator before scaling, saturation denominator
  logic [23:0]   t3_r, t3_nxt;
  logic [CW:0]   den3_r, den3_nxt, s3_r;
  logic [CW-1:0] d3_r, fs3_r;
  logic signed [TW-1:0] t_raw, dd, base;

  always_comb begin
    dd = $signed(TW'({1'b0, d2_r}));
    case (sel2_r)
      SEL_G:   base = dd * TW'(120);
      SEL_B:   base = dd * TW'(240);
      default: base = '0;
    endcase
    t_raw = TW'(dif2_r) * TW'(60) + base;
    if (t_raw < 0) t_raw = t_raw + dd * TW'(360);
    t3_nxt = t_raw[23:0];
    if (s2_r < {1'b0, fs2_r}) den3_nxt = s2_r;
    else                      den3_nxt = {fs2_r, 1'b0} - s2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r   <= t3_nxt;
      den3_r <= den3_nxt;
      s3_r   <= s2_r;
      d3_r   <= d2_r;
      fs3_r  <= fs2_r;
    end
  end

  // stage 4: rounded-division operands
  localparam int NW = rthsl_pkg::NUM_W;
  localparam int DW = rthsl_pkg::DEN_W;
  rthsl_pkg::div_bundle_t req_r, req_nxt;
  logic gray;

  always_comb begin
    gray = (d3_r == '0);
    req_nxt.light.num = NW'(s3_r) * NW'(rthsl_pkg::PCT_SCALE2) + NW'({fs3_r, 1'b0});
    req_nxt.light.den = DW'({fs3_r, 2'b00});
    if (gray) begin
      req_nxt.sat.num = '0;
      req_nxt.sat.den = DW'(2);
      req_nxt.hue.num = '0;
      req_nxt.hue.den = DW'(2);
    end else begin
      req_nxt.sat.num = NW'(d3_r) * NW'(rthsl_pkg::PCT_SCALE2) + NW'(den3_r);
      req_nxt.sat.den = DW'({den3_r, 1'b0});
      req_nxt.hue.num = NW'({t3_r, {(rthsl_pkg::HUE_FRAC_BITS + 1){1'b0}}}) + NW'(d3_r);
      req_nxt.hue.den = DW'({d3_r, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en) req_r <= req_nxt;
  end

  assign req = req_r;

endmodule

[design/rthsl_div.sv]
module rthsl_div (
  input  logic                          clk,
  input  logic                          en,
  input  rthsl_pkg::div_req_t           req,
  output logic [rthsl_pkg::QUO_W-1:0]   quot
);

  localparam int NW = rthsl_pkg::NUM_W;
  localparam int DW = rthsl_pkg::DEN_W;
  localparam int QW = rthsl_pkg::QUO_W;
  localparam int XW = NW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in, rem_nxt;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in, q_nxt;
    logic [XW-1:0] dsh;

    if (k == 0) begin : g_first
      assign rem_in = req.num;
      assign den_in = req.den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      dsh = XW'(den_in) << (QW - 1 - k);
      if (XW'(rem_in) >= dsh) begin
        rem_nxt = rem_in - NW'(dsh);
        q_nxt   = q_in | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quot = q_r[QW-1];

endmodule

[design/rthsl_back.sv]
module rthsl_back (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [rthsl_pkg::QUO_W-1:0]           hue_raw,
  input  logic [rthsl_pkg::QUO_W-1:0]           sat_raw,
  input  logic [rthsl_pkg::QUO_W-1:0]           light_raw,
  input  logic signed [rthsl_pkg::OFS_W-1:0]    hue_ofs,
  input  logic signed [rthsl_pkg::OFS_W-1:0]    sat_ofs,
  input  logic signed [rthsl_pkg::OFS_W-1:0]    light_ofs,
  output logic [rthsl_pkg::OUT_W-1:0]           hue,
  output logic [rthsl_pkg::OUT_W-1:0]           saturation,
  output logic [rthsl_pkg::OUT_W-1:0]           lightness
);

  localparam int SW = rthsl_pkg::QUO_W + 2;
  localparam int OW = rthsl_pkg::OUT_W;

  function automatic logic [OW-1:0] adj(input logic [rthsl_pkg::QUO_W-1:0] raw,
                                        input logic signed [rthsl_pkg::OFS_W-1:0] ofs,
                                        input int hi);
    logic signed [SW-1:0] sum;
    sum = $signed({2'b00, raw}) + SW'(ofs);
    if (sum < 0)                   return '0;
    else if (sum > SW'(hi))        return OW'(hi);
    else                           return sum[OW-1:0];
  endfunction

  logic [OW-1:0] hue_r, sat_r, light_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= adj(hue_raw, hue_ofs, rthsl_pkg::HUE_MAX);
      sat_r   <= adj(sat_raw, sat_ofs, rthsl_pkg::PCT_MAX);
      light_r <= adj(light_raw, light_ofs, rthsl_pkg::PCT_MAX);
    end
  end

  assign hue        = hue_r;
  assign saturation = sat_r;
  assign lightness  = light_r;

endmodule
